@@ rtl/core/int64_to_decimal_text_macros.svh @@
// Assertion macros used by the bound checker, i64dt_checker.
`ifndef INT64_TO_DECIMAL_TEXT_MACROS_SVH
`define INT64_TO_DECIMAL_TEXT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define I64DT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define I64DT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/i64dt_pkg.sv @@
package i64dt_pkg;

   // Decimal digits of the largest 64-bit magnitude.
   localparam int DIGITS = 20;
   localparam int ND_W = $clog2(DIGITS + 1);
   localparam int MAX_FIELD_DEF = 32;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   // Per-cycle command broadcast to every digit cell.
   typedef struct packed {
      logic clear;
      logic bin_shift;
      logic dig_shift;
   } cell_ctrl_type;

endpackage

@@ rtl/core/i64dt_digit_cell.sv @@
// One BCD digit of the conversion chain.
module i64dt_digit_cell (
   input  logic                     clock,
   input  i64dt_pkg::cell_ctrl_type ctrl,
   input  logic                     shift_bit,
   input  logic [3:0]               shift_digit,
   output logic                     carry_bit,
   output logic [3:0]               digit_q
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adj;

   // Add-three correction ahead of the binary shift.
   assign adj = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
   assign carry_bit = adj[3];
   assign digit_q = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = 4'd0;
      end else if (ctrl.bin_shift) begin
         digit_in = {adj[2:0], shift_bit};
      end else if (ctrl.dig_shift) begin
         digit_in = shift_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

@@ rtl/core/int64_to_decimal_text.sv @@
// Sequence: binary-to-BCD shifting of the magnitude, MSB first, then a skip of leading
// zero digits, then one character per cycle: the pad and sign characters first, then
// the digits. A new value is taken only while busy is low, that is from the cycle in
// which the last character of the previous value is shown.
// The receiver cannot stall: each character is shown for one cycle. Reset
// (synchronous, active high) returns the sequencer to idle and drops any pending character.
module int64_to_decimal_text #(
   parameter int MAX_FIELD = i64dt_pkg::MAX_FIELD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   input  logic        req_is_signed,
   input  logic [5:0]  req_field_width,
   output logic        rsp_valid,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_last_char
);

   localparam int DIGITS = i64dt_pkg::DIGITS;
   localparam int ND_W = i64dt_pkg::ND_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_NORM = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]      state_ff, state_in;
   logic [63:0]     mag_ff, mag_in;
   logic            neg_ff, neg_in;
   logic [5:0]      width_ff, width_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [ND_W-1:0] nd_ff, nd_in;
   logic [5:0]      pre_ff, pre_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_char_ff, rsp_char_in;
   logic            rsp_last_ff, rsp_last_in;

   i64dt_pkg::cell_ctrl_type ctrl;
   logic [3:0] digit_w [DIGITS];
   logic       carry_w [DIGITS];
   logic [3:0] top_digit;
   logic       req_neg;
   logic [5:0] nd_wide;
   logic [5:0] pre_calc;

   // Cell 0 is the least significant digit; bits and digits move upward.
   for (genvar g = 0; g < DIGITS; g++) begin : g_cell
      if (g == 0) begin : g_first
         i64dt_digit_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .shift_bit   (mag_ff[63]),
            .shift_digit (4'd0),
            .carry_bit   (carry_w[g]),
            .digit_q     (digit_w[g])
         );
      end else begin : g_rest
         i64dt_digit_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .shift_bit   (carry_w[g-1]),
            .shift_digit (digit_w[g-1]),
            .carry_bit   (carry_w[g]),
            .digit_q     (digit_w[g])
         );
      end
   end

   assign top_digit = digit_w[DIGITS-1];
   assign req_neg = req_is_signed & req_value[63];
   assign nd_wide = 6'(nd_ff);

   // Pad/sign characters ahead of the digits; the last of them carries the sign.
   always_comb begin
      if (width_ff == 6'd0) begin
         pre_calc = {5'd0, neg_ff};
      end else if (width_ff > nd_wide) begin
         pre_calc = width_ff - nd_wide;
      end else begin
         pre_calc = 6'd0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      width_in     = width_ff;
      cnt_in       = cnt_ff;
      nd_in        = nd_ff;
      pre_in       = pre_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // Take the magnitude; the most negative value stays exact as 2^63.
               mag_in = req_neg ? (64'd0 - req_value) : req_value;
               neg_in = req_neg;
               if (7'(req_field_width) > 7'(MAX_FIELD)) begin
                  width_in = 6'(MAX_FIELD);
               end else begin
                  width_in = req_field_width;
               end
               cnt_in     = 6'd0;
               nd_in      = ND_W'(DIGITS);
               ctrl.clear = 1'b1;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            // Shift one magnitude bit into the chain, MSB first.
            ctrl.bin_shift = 1'b1;
            mag_in = {mag_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (&cnt_ff) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // Drop leading zero digits, keeping at least one.
            if ((top_digit == 4'd0) && (nd_ff != ND_W'(1))) begin
               ctrl.dig_shift = 1'b1;
               nd_in = nd_ff - ND_W'(1);
            end else begin
               pre_in   = pre_calc;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            if (pre_ff != 6'd0) begin
               rsp_char_in = ((pre_ff == 6'd1) && neg_ff) ? i64dt_pkg::ASCII_MINUS
                                                          : i64dt_pkg::ASCII_SPACE;
               rsp_last_in = 1'b0;
               pre_in = pre_ff - 6'd1;
            end else begin
               // Hand out the top digit and advance the chain.
               rsp_char_in = i64dt_pkg::ASCII_ZERO + {4'd0, top_digit};
               rsp_last_in = (nd_ff == ND_W'(1));
               ctrl.dig_shift = 1'b1;
               nd_in = nd_ff - ND_W'(1);
               if (nd_ff == ND_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers hold no reset.
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      width_ff    <= width_in;
      cnt_ff      <= cnt_in;
      nd_ff       <= nd_in;
      pre_ff      <= pre_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

@@ rtl/core/i64dt_checker.sv @@
`include "int64_to_decimal_text_macros.svh"

module i64dt_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [7:0]  rsp_text_char,
   input logic        rsp_last_char
);

   `I64DT_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted transaction did not raise busy")
   `I64DT_ASSERT_NOW(a_end_last, clock, reset, $fell(busy) && !$past(reset), rsp_valid && rsp_last_char, "busy fell without a final character")
   `I64DT_ASSERT_NOW(a_last_idle, clock, reset, rsp_valid && rsp_last_char, !busy, "final character while still busy")
   `I64DT_ASSERT_NOW(a_last_digit, clock, reset, rsp_valid && rsp_last_char, (rsp_text_char >= i64dt_pkg::ASCII_ZERO) && (rsp_text_char <= i64dt_pkg::ASCII_NINE), "final character is not a digit")

endmodule

bind int64_to_decimal_text i64dt_checker u_i64dt_checker (.*);

@@ verif/int64_to_decimal_text_checker.sv @@
`timescale 1ns / 1ps

module int64_to_decimal_text_checker #(
   parameter int MAX_FIELD = i64dt_pkg::MAX_FIELD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [63:0] req_value,
   input  logic        req_is_signed,
   input  logic [5:0]  req_field_width,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_text_char,
   input  logic        rsp_last_char,
   output int          fail_count,
   output int          chars_outstanding,
   output int          values_taken,
   output int          chars_checked
);

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
   } text_char_type;

   text_char_type expected_text[$];
   int            failures = 0;
   int            values_cnt = 0;
   int            chars_cnt = 0;

   // Render one value as decimal text and queue its characters.
   function automatic void render_decimal(input logic [63:0] value, input logic is_signed,
                                          input logic [5:0] width_in);
      logic          negative;
      logic [63:0]   mag;
      logic [63:0]   rem;
      logic [7:0]    digit_chars[20];
      logic [7:0]    text[$];
      int            width;
      int            n_digits;
      text_char_type entry;
      negative = is_signed && value[63];
      mag = negative ? (~value + 64'd1) : value;
      width = (width_in > MAX_FIELD) ? MAX_FIELD : int'(width_in);
      n_digits = 0;
      do begin
         rem = mag % 64'd10;
         digit_chars[n_digits] = i64dt_pkg::ASCII_ZERO + rem[7:0];
         n_digits++;
         mag = mag / 64'd10;
      end while (mag != 64'd0);
      if (width == 0) begin
         if (negative) text.push_back(i64dt_pkg::ASCII_MINUS);
      end else if (width > n_digits) begin
         repeat (width - n_digits) text.push_back(i64dt_pkg::ASCII_SPACE);
         // the sign takes the last pad space
         if (negative) text[text.size() - 1] = i64dt_pkg::ASCII_MINUS;
      end
      for (int i = n_digits - 1; i >= 0; i--) text.push_back(digit_chars[i]);
      foreach (text[i]) begin
         entry.text_char = text[i];
         entry.last_char = (i == text.size() - 1);
         expected_text.push_back(entry);
      end
   endfunction

   function automatic void report_failure(input string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (rsp_valid) begin
            chars_cnt++;
            if (expected_text.size() == 0) begin
               report_failure($sformatf("unexpected char %h last %b", rsp_text_char,
                                        rsp_last_char));
            end else begin
               want = expected_text.pop_front();
               if (want.text_char !== rsp_text_char || want.last_char !== rsp_last_char)
                  report_failure($sformatf("char %0d: expected %h last %b, got %h last %b",
                                           chars_cnt, want.text_char, want.last_char,
                                           rsp_text_char, rsp_last_char));
            end
         end
         if (start && !busy) begin
            values_cnt++;
            render_decimal(req_value, req_is_signed, req_field_width);
         end
      end
      fail_count <= failures;
      chars_outstanding <= expected_text.size();
      values_taken <= values_cnt;
      chars_checked <= chars_cnt;
   end

endmodule

@@ verif/int64_to_decimal_text_tb.sv @@
`timescale 1ns / 1ps

module int64_to_decimal_text_tb;
   localparam int MAX_FIELD     = i64dt_pkg::MAX_FIELD_DEF;
   localparam int RESET_CYCLES  = 12;
   localparam int ITEMS_PER_RUN = 86;      // random transactions per idle profile
   localparam int DRAIN_CYCLES  = 200;     // quiet time after the queue empties, to catch stray characters
   localparam int CYCLE_LIMIT   = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_value = 64'd0;
   logic        req_is_signed = 1'b0;
   logic [5:0]  req_field_width = 6'd0;
   logic        rsp_valid;
   logic [7:0]  rsp_text_char;
   logic        rsp_last_char;

   int fail_count;
   int chars_outstanding;
   int values_taken;
   int chars_checked;
   int cycle_count = 0;
   int sender_idle_pct = 0;

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   int64_to_decimal_text #(.MAX_FIELD(MAX_FIELD)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .req_is_signed   (req_is_signed),
      .req_field_width (req_field_width),
      .rsp_valid       (rsp_valid),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char)
   );

   int64_to_decimal_text_checker #(.MAX_FIELD(MAX_FIELD)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_value         (req_value),
      .req_is_signed     (req_is_signed),
      .req_field_width   (req_field_width),
      .rsp_valid         (rsp_valid),
      .rsp_text_char     (rsp_text_char),
      .rsp_last_char     (rsp_last_char),
      .fail_count        (fail_count),
      .chars_outstanding (chars_outstanding),
      .values_taken      (values_taken),
      .chars_checked     (chars_checked)
   );

   // Hold one transaction on the request ports until the block takes it.
   // Idle cycles come first, with start low and junk on the payload so the
   // block is seen to ignore it. Start is never dropped and raised in the
   // same step: an item that follows without idling just overwrites the payload.
   task automatic send_value(input logic [63:0] value, input logic is_signed,
                             input logic [5:0] width);
      while ($urandom_range(99) < sender_idle_pct) begin
         start           <= 1'b0;
         req_value       <= {$urandom, $urandom};
         req_is_signed   <= 1'($urandom_range(1));
         req_field_width <= 6'($urandom_range(63));
         @(posedge clock);
      end
      start           <= 1'b1;
      req_value       <= value;
      req_is_signed   <= is_signed;
      req_field_width <= width;
      @(posedge clock);
      // accepted at the first edge that sees start high and busy low
      while (busy) @(posedge clock);
   endtask

   function automatic logic [63:0] power_of_ten(input int exponent);
      logic [63:0] p;
      p = 64'd1;
      repeat (exponent) p = p * 64'd10;
      return p;
   endfunction

   // Mix full-range values with short ones, decade boundaries and small
   // negatives; widths lean toward the padded range with some saturating ones.
   task automatic send_random_value();
      logic [63:0] value;
      logic        is_signed;
      logic [5:0]  width;
      int          pick;
      int          width_pick;
      pick = $urandom_range(9);
      is_signed = 1'($urandom_range(1));
      case (pick)
         0, 1, 2: value = {$urandom, $urandom};
         3, 4:    value = 64'($urandom_range(999));
         5:       value = 64'($urandom);
         6, 7:    value = power_of_ten($urandom_range(19)) + 64'($urandom_range(2)) - 64'd1;
         default: begin
            value = 64'd0 - 64'($urandom_range(99999));
            is_signed = ($urandom_range(3) != 0);
         end
      endcase
      width_pick = $urandom_range(9);
      if (width_pick < 2) width = 6'd0;
      else if (width_pick < 8) width = 6'($urandom_range(32, 1));
      else width = 6'($urandom_range(63, 33));
      send_value(value, is_signed, width);
   endtask

   // Watchdog: end the run if the block stops making progress.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed transactions: field extremes and the corner cases.
      sender_idle_pct = 9;
      send_value(64'd0, 1'b0, 6'd0);                        // zero, left-adjusted
      send_value(64'd0, 1'b1, 6'd5);                        // zero, padded
      send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd0);      // largest unsigned, 20 digits
      send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd32);     // widest pad
      send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd0);      // minus one
      send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd1);      // sign dropped, no pad room
      send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd2);      // sign takes the only pad
      send_value(64'h8000_0000_0000_0000, 1'b1, 6'd0);      // most negative, exact magnitude
      send_value(64'h8000_0000_0000_0000, 1'b1, 6'd21);     // two pads, the last becomes the sign
      send_value(64'h8000_0000_0000_0000, 1'b1, 6'd19);     // digits fill width, sign dropped
      send_value(64'h8000_0000_0000_0000, 1'b0, 6'd25);     // same bits, unsigned
      send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 6'd63);     // width saturates
      send_value(64'd12345, 1'b0, 6'd33);                   // just above the saturation point
      send_value(64'd0 - 64'd42, 1'b1, 6'd6);               // "   -42"
      send_value(64'd7, 1'b0, 6'd1);                        // single digit fills width
      send_value(64'd10, 1'b0, 6'd2);                       // digits fill width exactly
      send_value(64'd9, 1'b1, 6'd20);
      send_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 6'd42);     // alternating bit patterns
      send_value(64'h5555_5555_5555_5555, 1'b0, 6'd21);
      send_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 6'd0);
      send_value(64'h5555_5555_5555_5555, 1'b1, 6'd0);
      send_value(power_of_ten(18), 1'b0, 6'd19);
      send_value(power_of_ten(19), 1'b0, 6'd0);
      send_value(power_of_ten(19) - 64'd1, 1'b1, 6'd24);

      // Random transactions under three sender idle profiles.
      for (int profile = 0; profile < 3; profile++) begin
         sender_idle_pct = (profile == 0) ? 9 : (profile == 1) ? 48 : 0;
         repeat (ITEMS_PER_RUN) send_random_value();
      end
      start <= 1'b0;

      // Drain: wait for every queued character, then watch for strays.
      while (chars_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d values (signed and unsigned, widths 0 to 63) into %0d characters,",
               values_taken, chars_checked);
      $display("with sender gaps of 9%%, 48%% and none; %0d mismatches", fail_count);
      if (fail_count == 0 && chars_outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ int64_to_decimal_text.f @@
+incdir+rtl/core
rtl/core/i64dt_pkg.sv
rtl/core/i64dt_digit_cell.sv
rtl/core/int64_to_decimal_text.sv
rtl/core/i64dt_checker.sv
verif/int64_to_decimal_text_checker.sv
verif/int64_to_decimal_text_tb.sv
